FILE: sv/first_unique_symbol_stream_unit_macros.svh
`ifndef FIRST_UNIQUE_SYMBOL_STREAM_UNIT_MACROS_SVH
`define FIRST_UNIQUE_SYMBOL_STREAM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FUSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FUSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/fuss_pkg.sv
package fuss_pkg;

  localparam int SYM_W = 8;
  localparam int CNT_W = 2;
  // count saturates here, meaning two or more
  localparam logic [CNT_W-1:0] CNT_MAX = 2'd2;
  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_FRONT,
    S_FCNT_RD,
    S_FCHK,
    S_EMIT
  } fuss_state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

FILE: sv/first_unique_symbol_stream_unit.sv
// channel  | ports                      | content
// ---------+----------------------------+---------------------------------------
// input    | in_tvalid/tready/tdata     | tdata[7:0] symbol
// result   | out_tvalid/tready/tdata    | tuser found, tdata[7:0] first_unique
//
// each item runs S_IDLE, S_CNT and S_FRONT, then S_FCNT_RD and S_FCHK back to
// S_FRONT for each dropped front entry, and ends in S_EMIT; the count store
// read port serves both the update and each front check
// reset clears the count store through per-entry valid bits, no sweep
// in_tready is high only while the sequencer is idle; a held result stalls
// the next item only at its final step
`include "first_unique_symbol_stream_unit_macros.svh"

module first_unique_symbol_stream_unit #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] first_unique
  output logic       out_tuser   // [0] found
);
  import fuss_pkg::*;

  localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  fuss_state_t state_r, state_nxt;
  logic [IDX_W-1:0] sym_r;
  logic in_range_r;
  logic out_valid_r;
  logic out_found_r;
  logic [SYM_W-1:0] out_sym_r;

  logic cnt_rd_en, cnt_wr_en;
  logic [IDX_W-1:0] cnt_rd_addr;
  logic [CNT_W-1:0] cnt_rd, cnt_wr;
  ring_ctrl_t ring_ctrl;
  ring_stat_t ring_stat;
  logic [IDX_W-1:0] front_sym;
  logic in_xfer, emit;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign emit      = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  fuss_count_store #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_cnt  (cnt_rd),
    .wr_en   (cnt_wr_en),
    .wr_addr (sym_r),
    .wr_cnt  (cnt_wr)
  );

  fuss_order_ring #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ring_ctrl),
    .push_sym  (sym_r),
    .front_sym (front_sym),
    .stat      (ring_stat)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = front_sym;
    cnt_wr_en   = 1'b0;
    cnt_wr      = cnt_rd + 1'b1;
    ring_ctrl   = '0;
    unique case (state_r)
      S_IDLE: begin
        cnt_rd_addr = in_tdata[IDX_W-1:0];
        cnt_rd_en   = in_xfer;
        if (in_xfer) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        // first occurrence joins the ring, count saturates at two
        ring_ctrl.push = in_range_r && (cnt_rd == CNT_NONE);
        cnt_wr_en      = in_range_r && (cnt_rd != CNT_MAX);
        state_nxt      = S_FRONT;
      end
      S_FRONT: begin
        ring_ctrl.rd = !ring_stat.empty;
        state_nxt    = ring_stat.empty ? S_EMIT : S_FCNT_RD;
      end
      S_FCNT_RD: begin
        cnt_rd_en = 1'b1;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (cnt_rd == CNT_MAX) begin
          ring_ctrl.pop = 1'b1;
          state_nxt     = S_FRONT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sym_r      <= in_tdata[IDX_W-1:0];
      in_range_r <= ({1'b0, in_tdata} < 9'(ALPHABET_SIZE));
    end
    if (emit) begin
      out_found_r <= !ring_stat.empty;
      out_sym_r   <= ring_stat.empty ? '0 : SYM_W'(front_sym);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_found_r;

  `FUSS_ASSERT_NOW(a_notfound_zero, out_tvalid && !out_tuser, out_tdata == '0, "not-found result carries a nonzero symbol")
  `FUSS_ASSERT_NEXT(a_busy_after_xfer, in_tvalid && in_tready, !in_tready, "input ready right after a transfer")
  `FUSS_ASSERT_NEXT(a_empty_emits, state_r == S_FRONT && ring_stat.empty, state_r == S_EMIT, "empty ring did not go to emit")

endmodule

FILE: sv/fuss_count_store.sv
module fuss_count_store #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           rd_en,
  input  logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] rd_addr,
  output logic [fuss_pkg::CNT_W-1:0]                     rd_cnt,
  input  logic                                           wr_en,
  input  logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] wr_addr,
  input  logic [fuss_pkg::CNT_W-1:0]                     wr_cnt
);
  import fuss_pkg::*;

  logic [CNT_W-1:0] mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_r;
  logic [CNT_W-1:0] rd_data_r;
  logic rd_vld_r;

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_cnt = rd_vld_r ? rd_data_r : CNT_NONE;

endmodule

FILE: sv/fuss_order_ring.sv
module fuss_order_ring #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  fuss_pkg::ring_ctrl_t                           ctrl,
  input  logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] push_sym,
  output logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] front_sym,
  output fuss_pkg::ring_stat_t                           stat
);
  import fuss_pkg::*;

  localparam int IDX_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int FILL_W = $clog2(ALPHABET_SIZE + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ALPHABET_SIZE);

  logic [IDX_W-1:0] mem [ALPHABET_SIZE];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] front_r;
  logic do_push;

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FULL_FILL);
  assign do_push    = ctrl.push && !stat.full;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (do_push) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
    end
    if (ctrl.pop && !stat.empty) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
    case ({do_push, ctrl.pop && !stat.empty})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= push_sym;
    end
    if (ctrl.rd) begin
      front_r <= mem[head_r];
    end
  end

  assign front_sym = front_r;

endmodule

FILE: tb/first_unique_symbol_stream_unit_tb.sv
`timescale 1ns / 1ps

module first_unique_symbol_stream_unit_tb;
  import fuss_pkg::*;

  localparam int ALPHABET = 256;
  localparam int RANDOM_ITEMS = 1730;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 29;

  typedef struct {
    logic             found;
    logic [SYM_W-1:0] symbol;
  } answer_t;

  // tracks occurrence counts and first-occurrence order, predicts each answer
  class unique_symbol_tracker;
    logic [CNT_W-1:0] seen [ALPHABET];
    logic [SYM_W-1:0] order [ALPHABET];
    logic [SYM_W-1:0] head;
    logic [SYM_W-1:0] tail;
    logic [SYM_W:0]   fill;
    answer_t          answers_due [$];
    int               errors;

    function new();
      foreach (seen[i]) seen[i] = CNT_NONE;
      foreach (order[i]) order[i] = '0;
      head = '0;
      tail = '0;
      fill = '0;
      errors = 0;
    endfunction

    function void take_symbol(logic [SYM_W-1:0] sym);
      answer_t a;
      if (seen[sym] == CNT_NONE && fill < ALPHABET) begin
        order[tail] = sym;
        tail++;
        fill++;
      end
      if (seen[sym] != CNT_MAX) seen[sym] = seen[sym] + 1'b1;
      // drop repeated symbols from the front
      while (fill != 0 && seen[order[head]] == CNT_MAX) begin
        head++;
        fill--;
      end
      a.found = (fill != 0);
      a.symbol = a.found ? order[head] : '0;
      answers_due.push_back(a);
    endfunction

    function void note_mismatch(string field, int want, int got);
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_answer(logic found, logic [SYM_W-1:0] symbol);
      answer_t want;
      if (answers_due.size() == 0) begin
        note_mismatch("unexpected transfer, symbol", -1, symbol);
        return;
      end
      want = answers_due.pop_front();
      if (found !== want.found) note_mismatch("found", want.found, found);
      if (symbol !== want.symbol) note_mismatch("first_unique", want.symbol, symbol);
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] symbol
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [7:0] first_unique
  logic       out_tuser;       // [0] found

  logic calm = 1'b0;
  int   cycles = 0;
  int   fresh_order [ALPHABET];
  int   fresh_idx = 0;

  unique_symbol_tracker sb = new();

  first_unique_symbol_stream_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_answer(out_tuser, out_tdata);
  end

  task automatic send_symbol(input logic [7:0] sym);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sym;
    do @(posedge clk); while (!in_tready);
    sb.take_symbol(sym);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
  endtask

  // mix of first occurrences, repeats of queued symbols and random noise that leans toward saturated symbols
  function automatic logic [7:0] pick_symbol();
    int         r;
    logic [7:0] s;
    r = $urandom_range(99);
    if (r < 12) begin
      while (fresh_idx < ALPHABET && sb.seen[fresh_order[fresh_idx]] != CNT_NONE)
        fresh_idx++;
      if (fresh_idx < ALPHABET) return 8'(fresh_order[fresh_idx]);
    end
    if (r < 30 && sb.fill != 0)
      return sb.order[SYM_W'(sb.head + $urandom_range(sb.fill - 1))];
    s = 8'($urandom_range(255));
    if (r >= 45)
      repeat (8) if (sb.seen[s] != CNT_MAX) s = 8'($urandom_range(255));
    return s;
  endfunction

  initial begin
    logic [7:0] directed [] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
                                8'h80, 8'hAA, 8'h55, 8'h55, 8'h01, 8'h80, 8'h7F,
                                8'h7F, 8'hFE, 8'h7F, 8'hFE};
    int         j;
    int         t;

    foreach (fresh_order[i]) fresh_order[i] = i;
    for (int i = ALPHABET - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = fresh_order[i];
      fresh_order[i] = fresh_order[j];
      fresh_order[j] = t;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_symbol(directed[i]);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 700 && n < 1000);
      if (n == 1200) wait_drained();
      send_symbol(pick_symbol());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.answers_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/fuss_pkg.sv
sv/fuss_count_store.sv
sv/fuss_order_ring.sv
sv/first_unique_symbol_stream_unit.sv
tb/first_unique_symbol_stream_unit_tb.sv
